@@ src/mciir_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mciir_pkg
// Shared types and constants of the multichannel direct form I IIR filter.
// ----------------------------------------------------------------------------
package mciir_pkg;

  // fixed field widths and number formats
  localparam int SAMPLE_W  = 32;
  localparam int FRAC_BITS = 16;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int TAPS      = 8;
  localparam int TAP_W     = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FF_B0_B1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FF_B2_B3 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FF_B4_B5 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FF_B6_B7 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FB_A1_A2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FB_A3_A4 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FB_A5_A6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FB_A7    = 3'd7;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  // control flags that travel with one tap through the mac pipeline
  typedef struct packed {
    logic valid;
    logic first_tap;
    logic last_tap;
    logic last_ch;
  } ctl_t;

endpackage

@@ src/mciir_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mciir_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mciir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/mciir_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mciir_mac
// Dual multiply and accumulate pipeline: feedforward and feedback products
// of one tap per cycle; a wrapping 32-bit accumulator sums b*x minus a*y.
// ----------------------------------------------------------------------------
module mciir_mac #(
  parameter int CH_W = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mciir_pkg::ctl_t                issue_ctl,
  input  logic [CH_W-1:0]                issue_ch,
  input  logic [mciir_pkg::SAMPLE_W-1:0] issue_coef_b,
  input  logic [mciir_pkg::SAMPLE_W-1:0] issue_coef_a,
  input  logic [mciir_pkg::SAMPLE_W-1:0] issue_x_new,
  input  logic [mciir_pkg::SAMPLE_W-1:0] rd_x,
  input  logic [mciir_pkg::SAMPLE_W-1:0] rd_y,
  output mciir_pkg::ctl_t                res_ctl,
  output logic [CH_W-1:0]                res_ch,
  output logic [mciir_pkg::SAMPLE_W-1:0] res_data
);
  import mciir_pkg::*;

  ctl_t                ctl1, ctl2, ctl3;
  logic [CH_W-1:0]     ch1, ch2, ch3;
  logic [SAMPLE_W-1:0] cb1, ca1, xn1;
  logic [SAMPLE_W-1:0] x_op;
  logic signed [2*SAMPLE_W-1:0] prod_x, prod_y;
  logic [SAMPLE_W-1:0] px, py;
  logic [SAMPLE_W-1:0] acc;

  // stage 1: align operands with the ram read data
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else begin
      ctl1 <= issue_ctl;
    end
    ch1 <= issue_ch;
    cb1 <= issue_coef_b;
    ca1 <= issue_coef_a;
    xn1 <= issue_x_new;
  end

  // newest sample bypasses the ram, it is written in the same cycle
  assign x_op   = ctl1.first_tap ? xn1 : rd_x;
  assign prod_x = $signed(cb1) * $signed(x_op);
  assign prod_y = $signed(ca1) * $signed(rd_y);

  // stage 2: products, floor shift by the fraction bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2 <= '0;
    end else begin
      ctl2 <= ctl1;
    end
    ch2 <= ch1;
    px  <= prod_x[FRAC_BITS +: SAMPLE_W];
    py  <= prod_y[FRAC_BITS +: SAMPLE_W];
  end

  // stage 3: wrapping accumulation, restarted on the first tap
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3 <= '0;
    end else begin
      ctl3 <= ctl2;
    end
    ch3 <= ch2;
    if (ctl2.valid) begin
      acc <= (ctl2.first_tap ? '0 : acc) + px - py;
    end
  end

  assign res_ctl  = ctl3;
  assign res_ch   = ch3;
  assign res_data = acc;

endmodule

@@ src/multichannel_iir_direct_form_one.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_iir_direct_form_one
// Order 7 direct form I IIR filter over CHANNELS channels, Q16.16 fixed point,
// with input and output history kept in two rams.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one transfer carries one sample per channel, channel 0 in
//   the lowest 32 bits. m_* channel: one transfer per input transfer, the
//   filtered samples in the same lane order.
//   cfg_we/cfg_index/cfg_data load the coefficient registers; write them only
//   while the filter is idle.
//   Each item runs 8 taps per channel through one pair of multipliers
//   (feedforward and feedback), one tap per cycle; the next item is taken
//   only after the finished item has been handed to the output register.
//   A finished result waits in the output register; a new item is accepted
//   while it waits, and a completed item is held back until the output
//   register is free.
//   After reset, the history rams are cleared one entry a cycle, all
//   RAM_D = 2**(CH_W+POS_W) entries (32 by default), with s_tready low.
//   Coefficients reset to zero.
// ----------------------------------------------------------------------------
module multichannel_iir_direct_form_one #(
  parameter int CHANNELS      = 4,
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // sample_0 .. sample_N, 32 bits each, from bit 0 up
  input  logic [CHANNELS*mciir_pkg::SAMPLE_W-1:0] s_tdata,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // filtered_0 .. filtered_N, 32 bits each, from bit 0 up
  output logic [CHANNELS*mciir_pkg::SAMPLE_W-1:0] m_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  input  logic                                  cfg_we,
  input  logic [mciir_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mciir_pkg::CFG_W-1:0]           cfg_data
);
  import mciir_pkg::*;

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W = $clog2(HISTORY_DEPTH);
  localparam int ADR_W = CH_W + POS_W;
  localparam int RAM_D = 2 ** ADR_W;
  localparam int DW    = CHANNELS * SAMPLE_W;

  state_t state;

  logic [SAMPLE_W-1:0] coef_b [TAPS];
  logic [SAMPLE_W-1:0] coef_a [TAPS];

  logic [DW-1:0]       s_data_q;
  logic [CHANNELS-1:0][SAMPLE_W-1:0] work;
  logic [POS_W-1:0]    pos;
  logic [CH_W-1:0]     ch;
  logic [TAP_W-1:0]    tap;
  logic [ADR_W-1:0]    clr_addr;

  logic [POS_W:0]      pos_x, tap_x, tap_diff;
  logic [POS_W-1:0]    tap_pos;
  logic [SAMPLE_W-1:0] cur_sample;

  ctl_t                issue_ctl, res_ctl;
  logic [CH_W-1:0]     res_ch;
  logic [SAMPLE_W-1:0] res_data;
  logic                res_done, out_free;

  logic                xh_we, yh_we;
  logic [ADR_W-1:0]    xh_waddr, yh_waddr, rd_addr;
  logic [SAMPLE_W-1:0] xh_wdata, yh_wdata, rd_x, rd_y;

  // coefficient registers, a0 stays zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++) begin
        coef_b[i] <= '0;
        coef_a[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FF_B0_B1: begin
          coef_b[0] <= cfg_data[31:0];
          coef_b[1] <= cfg_data[63:32];
        end
        REG_FF_B2_B3: begin
          coef_b[2] <= cfg_data[31:0];
          coef_b[3] <= cfg_data[63:32];
        end
        REG_FF_B4_B5: begin
          coef_b[4] <= cfg_data[31:0];
          coef_b[5] <= cfg_data[63:32];
        end
        REG_FF_B6_B7: begin
          coef_b[6] <= cfg_data[31:0];
          coef_b[7] <= cfg_data[63:32];
        end
        REG_FB_A1_A2: begin
          coef_a[1] <= cfg_data[31:0];
          coef_a[2] <= cfg_data[63:32];
        end
        REG_FB_A3_A4: begin
          coef_a[3] <= cfg_data[31:0];
          coef_a[4] <= cfg_data[63:32];
        end
        REG_FB_A5_A6: begin
          coef_a[5] <= cfg_data[31:0];
          coef_a[6] <= cfg_data[63:32];
        end
        REG_FB_A7: begin
          coef_a[7] <= cfg_data[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  // ring slot of the current tap: pos - tap modulo the history depth
  always_comb begin
    pos_x = {1'b0, pos};
    tap_x = (POS_W+1)'(tap);
    if (pos_x >= tap_x) begin
      tap_diff = pos_x - tap_x;
    end else begin
      tap_diff = pos_x + (POS_W+1)'(HISTORY_DEPTH) - tap_x;
    end
  end
  assign tap_pos    = tap_diff[POS_W-1:0];
  assign cur_sample = s_data_q[ch*SAMPLE_W +: SAMPLE_W];

  // issue side of the mac pipeline
  always_comb begin
    issue_ctl.valid     = (state == ST_RUN);
    issue_ctl.first_tap = (tap == '0);
    issue_ctl.last_tap  = (tap == TAP_W'(TAPS-1));
    issue_ctl.last_ch   = (ch == CH_W'(CHANNELS-1));
  end

  assign rd_addr  = {ch, tap_pos};
  assign res_done = res_ctl.valid && res_ctl.last_tap;
  assign out_free = !m_tvalid || m_tready;

  // history ram write ports: clearing pass, new sample, new result
  always_comb begin
    xh_we    = 1'b0;
    xh_waddr = {ch, pos};
    xh_wdata = cur_sample;
    yh_we    = res_done;
    yh_waddr = {res_ch, pos};
    yh_wdata = res_data;
    if (state == ST_CLEAR) begin
      xh_we    = 1'b1;
      xh_waddr = clr_addr;
      xh_wdata = '0;
      yh_we    = 1'b1;
      yh_waddr = clr_addr;
      yh_wdata = '0;
    end else if (state == ST_RUN && tap == '0) begin
      xh_we = 1'b1;
    end
  end

  mciir_ram #(.WIDTH(SAMPLE_W), .DEPTH(RAM_D)) u_x_hist (
    .clk   (clk),
    .we    (xh_we),
    .waddr (xh_waddr),
    .wdata (xh_wdata),
    .raddr (rd_addr),
    .rdata (rd_x)
  );

  mciir_ram #(.WIDTH(SAMPLE_W), .DEPTH(RAM_D)) u_y_hist (
    .clk   (clk),
    .we    (yh_we),
    .waddr (yh_waddr),
    .wdata (yh_wdata),
    .raddr (rd_addr),
    .rdata (rd_y)
  );

  mciir_mac #(.CH_W(CH_W)) u_mac (
    .clk          (clk),
    .rst          (rst),
    .issue_ctl    (issue_ctl),
    .issue_ch     (ch),
    .issue_coef_b (coef_b[tap]),
    .issue_coef_a (coef_a[tap]),
    .issue_x_new  (cur_sample),
    .rd_x         (rd_x),
    .rd_y         (rd_y),
    .res_ctl      (res_ctl),
    .res_ch       (res_ch),
    .res_data     (res_data)
  );

  assign s_tready = (state == ST_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      ch       <= '0;
      tap      <= '0;
      pos      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // output valid: raised by a finished item, dropped on transfer
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            ch    <= '0;
            tap   <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (tap == TAP_W'(TAPS-1)) begin
            tap <= '0;
            if (ch == CH_W'(CHANNELS-1)) begin
              ch    <= '0;
              state <= ST_DRAIN;
            end else begin
              ch <= ch + 1'b1;
            end
          end else begin
            tap <= tap + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (res_done && res_ctl.last_ch) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            pos      <= (pos == POS_W'(HISTORY_DEPTH-1)) ? '0 : pos + 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s_data_q <= s_tdata;
    end
    if (res_done) begin
      work[res_ch] <= res_data;
    end
    if (state == ST_DONE && out_free) begin
      m_tdata <= work;
    end
  end

endmodule

@@ src/mciir_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mciir_checker
// Port-level checks of the filter's stream handshakes over time.
// ----------------------------------------------------------------------------
module mciir_checker #(
  parameter int DATA_W = 128
) (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [DATA_W-1:0] m_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result data changed while stalled");

  // one item at a time: no input transfer right after another
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in work");

  // reset empties the output and starts the clearing pass
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("output or input open right after reset");

endmodule

bind multichannel_iir_direct_form_one mciir_checker #(.DATA_W($bits(m_tdata))) u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
